[rtl/dds_pkg.sv]
// Package for the delay-difference biomass step unit.
// Holds sequencer step codes, command struct, widths and the exp tables.
// No dependencies.
package dds_pkg;

  localparam int unsigned MonthsPerYearDef = 12;
  localparam int unsigned RecruitMonthDef  = 6;

  localparam int unsigned STEP_W = 5;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_Q_TGT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_Q_NTGT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NAT_M   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RHO     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WK      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WK1     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_B_INIT0 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_B_INIT1 = 3'd7;

  // datapath steps; 15 of the 18 use the one shared multiplier
  localparam logic [STEP_W-1:0] ST_MUL_QT   = 5'd0;
  localparam logic [STEP_W-1:0] ST_MUL_QN   = 5'd1;
  localparam logic [STEP_W-1:0] ST_SUM_X    = 5'd2;
  localparam logic [STEP_W-1:0] ST_SQ       = 5'd3;
  localparam logic [STEP_W-1:0] ST_CUBE     = 5'd4;
  localparam logic [STEP_W-1:0] ST_EXP_TAB  = 5'd5;
  localparam logic [STEP_W-1:0] ST_EXP_POLY = 5'd6;
  localparam logic [STEP_W-1:0] ST_S1B1     = 5'd7;
  localparam logic [STEP_W-1:0] ST_RHO_A    = 5'd8;
  localparam logic [STEP_W-1:0] ST_WK_REC   = 5'd9;
  localparam logic [STEP_W-1:0] ST_S1S2     = 5'd10;
  localparam logic [STEP_W-1:0] ST_SS_B2    = 5'd11;
  localparam logic [STEP_W-1:0] ST_RHO_T    = 5'd12;
  localparam logic [STEP_W-1:0] ST_RHO_S1   = 5'd13;
  localparam logic [STEP_W-1:0] ST_RS_WK1   = 5'd14;
  localparam logic [STEP_W-1:0] ST_U_R1     = 5'd15;
  localparam logic [STEP_W-1:0] ST_NEG_ACC  = 5'd16;
  localparam logic [STEP_W-1:0] ST_FINAL    = 5'd17;

  typedef struct packed {
    logic              load;
    logic [STEP_W-1:0] step;
    logic              commit;
  } dds_cmd_t;

  function automatic logic [23:0] expi_lut(input logic [3:0] n);
    logic [23:0] v;
    case (n)
      4'd0:  v = 24'd16777215 + 24'd1;
      4'd1:  v = 24'd6171993;
      4'd2:  v = 24'd2270549;
      4'd3:  v = 24'd835288;
      4'd4:  v = 24'd307285;
      4'd5:  v = 24'd113044;
      4'd6:  v = 24'd41587;
      4'd7:  v = 24'd15299;
      4'd8:  v = 24'd5628;
      4'd9:  v = 24'd2070;
      4'd10: v = 24'd762;
      4'd11: v = 24'd280;
      default: v = 24'd0;
    endcase
    return v;
  endfunction

  // 2^24 does not fit 24 bits; table entries carried at 25 bits
  function automatic logic [24:0] expi_val(input logic [3:0] n);
    return (n == 4'd0) ? 25'd16777216 : {1'b0, expi_lut(n)};
  endfunction

  function automatic logic [24:0] expf_val(input logic [3:0] k);
    logic [24:0] v;
    case (k)
      4'd0:  v = 25'd16777216;
      4'd1:  v = 25'd15760736;
      4'd2:  v = 25'd14805841;
      4'd3:  v = 25'd13908801;
      4'd4:  v = 25'd13066109;
      4'd5:  v = 25'd12274473;
      4'd6:  v = 25'd11530801;
      4'd7:  v = 25'd10832185;
      4'd8:  v = 25'd10175896;
      4'd9:  v = 25'd9559370;
      4'd10: v = 25'd8980197;
      4'd11: v = 25'd8436114;
      4'd12: v = 25'd7924996;
      4'd13: v = 25'd7444844;
      4'd14: v = 25'd6993784;
      4'd15: v = 25'd6570052;
      default: v = 25'd0;
    endcase
    return v;
  endfunction

endpackage

[rtl/dds_if.sv]
// Valid/ready channel interfaces for the biomass step unit.
// Uses no package.
interface dds_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] effort_targeted;
  logic [15:0] effort_nontargeted;
  logic [31:0] year_recruitment;
  logic        series_start;
  modport source (output valid, effort_targeted, effort_nontargeted, year_recruitment,
                  series_start, input ready);
  modport sink (input valid, effort_targeted, effort_nontargeted, year_recruitment,
                series_start, output ready);
endinterface

interface dds_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] biomass;
  logic        clamped;
  modport source (output valid, biomass, clamped, input ready);
  modport sink (input valid, biomass, clamped, output ready);
endinterface

[rtl/dds_ctrl.sv]
// Sequencer for the biomass step unit: accepts words, steps the datapath,
// hands off to the output register. Depends on dds_pkg.
module dds_ctrl import dds_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output dds_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic              state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              ovalid_r, ovalid_nxt;
  logic              out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ovalid_r;
  assign out_free  = !ovalid_r || out_ready;

  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    ovalid_nxt = ovalid_r && !out_ready;
    cmd.load   = 1'b0;
    cmd.commit = 1'b0;
    cmd.step   = step_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_RUN;
          step_nxt  = ST_MUL_QT;
        end
      end
      S_RUN: begin
        if (step_r == ST_FINAL) begin
          if (out_free) begin
            cmd.commit = 1'b1;
            ovalid_nxt = 1'b1;
            state_nxt  = S_IDLE;
          end
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      step_r   <= ST_MUL_QT;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      step_r   <= step_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

endmodule

[rtl/dds_datapath.sv]
// Datapath: config registers, model state, one shared 32x32 multiplier,
// survival exp and the recursion accumulators. Depends on dds_pkg.
module dds_datapath import dds_pkg::*; #(
  parameter int unsigned MONTHS_PER_YEAR = MonthsPerYearDef,
  parameter int unsigned RECRUIT_MONTH   = RecruitMonthDef
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dds_cmd_t              cmd,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [15:0]           in_et,
  input  logic [15:0]           in_en,
  input  logic [31:0]           in_yr,
  input  logic                  in_start,
  output logic [31:0]           out_biomass,
  output logic                  out_clamped
);

  localparam logic [3:0] MonthsLim = 4'(MONTHS_PER_YEAR);
  localparam logic [3:0] RecMonth  = 4'(RECRUIT_MONTH);

  // configuration
  logic [31:0] qt_r, qn_r, wk_r, wk1_r, binit0_r, binit1_r;
  logic [23:0] natm_r;
  logic [16:0] rho_raw_r;

  // model state
  logic [31:0] b1_r, b2_r, r1_r;
  logic [16:0] s1_r, s2_r;
  logic [3:0]  month_r;
  logic [1:0]  early_r;

  // work registers
  logic [15:0] et_r, en_r;
  logic [31:0] yr_r;
  logic [49:0] x_r;
  logic [23:0] sq_r;
  logic [25:0] p_r;
  logic [63:0] prod_r;
  logic [16:0] surv_r;
  logic [49:0] pos_r, neg_r;
  logic [31:0] obio_r;
  logic        oclamp_r;

  logic [31:0] mul_a, mul_b;
  logic [16:0] rho;
  logic [31:0] rec;
  logic [31:0] ph;
  logic [11:0] r12;
  logic        x_big;
  logic [10:0] c_hi;
  logic [23:0] c_mul;
  logic [25:0] p_val;
  logic [24:0] v_q24;
  logic [24:0] v_rnd;
  logic [49:0] diff;
  logic [31:0] res;
  logic        flag;

  assign rho   = (rho_raw_r > 17'd65536) ? 17'd65536 : rho_raw_r;
  assign rec   = (month_r == RecMonth) ? yr_r : 32'd0;
  assign ph    = prod_r[47:16];
  assign r12   = x_r[11:0];
  assign x_big = (x_r >= 50'(32'd12 << 16));
  // cube term: floor(r^3 / (6 * 2^24)) = floor((r^3 >> 25) / 3)
  assign c_hi  = prod_r[35:25];
  assign c_mul = 24'(c_hi) * 24'd2731;
  assign p_val = 26'd16777216 - 26'({r12, 8'd0}) + 26'(sq_r[23:9]) - 26'(c_mul[23:13]);
  assign v_q24 = prod_r[48:24];
  assign v_rnd = v_q24 + 25'd128;

  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (cmd.step)
      ST_MUL_QT:   begin mul_a = qt_r;               mul_b = 32'(et_r);   end
      ST_MUL_QN:   begin mul_a = qn_r;               mul_b = 32'(en_r);   end
      ST_SQ:       begin mul_a = 32'(r12);           mul_b = 32'(r12);    end
      ST_CUBE:     begin mul_a = 32'(prod_r[23:0]);  mul_b = 32'(r12);    end
      ST_EXP_TAB:  begin mul_a = 32'(expi_val(x_r[19:16]));
                         mul_b = 32'(expf_val(x_r[15:12]));               end
      ST_EXP_POLY: begin mul_a = 32'(v_q24);         mul_b = 32'(p_r);    end
      ST_S1B1:     begin mul_a = 32'(s1_r);          mul_b = b1_r;        end
      ST_RHO_A:    begin mul_a = 32'(rho);           mul_b = ph;          end
      ST_WK_REC:   begin mul_a = wk_r;               mul_b = rec;         end
      ST_S1S2:     begin mul_a = 32'(s1_r);          mul_b = 32'(s2_r);   end
      ST_SS_B2:    begin mul_a = ph;                 mul_b = b2_r;        end
      ST_RHO_T:    begin mul_a = 32'(rho);           mul_b = ph;          end
      ST_RHO_S1:   begin mul_a = 32'(rho);           mul_b = 32'(s1_r);   end
      ST_RS_WK1:   begin mul_a = ph;                 mul_b = wk1_r;       end
      ST_U_R1:     begin mul_a = ph;                 mul_b = r1_r;        end
      default:     begin mul_a = 32'd0;              mul_b = 32'd0;       end
    endcase
  end

  always_comb begin
    diff = pos_r - neg_r;
    flag = 1'b0;
    if (early_r == 2'd0) begin
      res = binit0_r;
    end else if (early_r == 2'd1) begin
      res = binit1_r;
    end else if (neg_r > pos_r) begin
      res  = 32'd0;
      flag = 1'b1;
    end else if (diff[49:32] != 18'd0) begin
      res  = 32'hFFFF_FFFF;
      flag = 1'b1;
    end else begin
      res = diff[31:0];
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= 64'(mul_a) * 64'(mul_b);
    if (cmd.load) begin
      et_r <= in_et;
      en_r <= in_en;
      yr_r <= in_yr;
    end
    case (cmd.step)
      ST_MUL_QN:   x_r   <= 50'(natm_r) + 50'(prod_r[47:0]);
      ST_SUM_X:    x_r   <= x_r + 50'(prod_r[47:0]);
      ST_CUBE:     sq_r  <= prod_r[23:0];
      ST_EXP_TAB:  p_r   <= p_val;
      ST_S1B1:     surv_r <= x_big ? 17'd0 : v_rnd[24:8];
      ST_RHO_A:    pos_r <= 50'(ph);
      ST_WK_REC:   pos_r <= pos_r + 50'(ph);
      ST_S1S2:     pos_r <= pos_r + 50'(prod_r[63:16]);
      ST_RHO_S1:   neg_r <= 50'(ph);
      ST_NEG_ACC:  neg_r <= neg_r + 50'(prod_r[63:16]);
      default: ;
    endcase
    if (cmd.commit) begin
      obio_r   <= res;
      oclamp_r <= flag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qt_r <= '0; qn_r <= '0; natm_r <= '0; rho_raw_r <= '0;
      wk_r <= '0; wk1_r <= '0; binit0_r <= '0; binit1_r <= '0;
      b1_r <= '0; b2_r <= '0; s1_r <= '0; s2_r <= '0; r1_r <= '0;
      month_r <= '0; early_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_Q_TGT:   qt_r      <= cfg_data;
          REG_Q_NTGT:  qn_r      <= cfg_data;
          REG_NAT_M:   natm_r    <= cfg_data[23:0];
          REG_RHO:     rho_raw_r <= cfg_data[16:0];
          REG_WK:      wk_r      <= cfg_data;
          REG_WK1:     wk1_r     <= cfg_data;
          REG_B_INIT0: binit0_r  <= cfg_data;
          REG_B_INIT1: binit1_r  <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load && in_start) begin
        month_r <= '0;
        early_r <= '0;
      end
      if (cmd.commit) begin
        b2_r    <= b1_r;
        b1_r    <= res;
        s2_r    <= s1_r;
        s1_r    <= surv_r;
        r1_r    <= rec;
        month_r <= (5'(month_r) + 5'd1 >= 5'(MonthsLim)) ? 4'd0 : month_r + 4'd1;
        if (early_r != 2'd2) early_r <= early_r + 2'd1;
      end
    end
  end

  assign out_biomass = obio_r;
  assign out_clamped = oclamp_r;

endmodule

[rtl/delay_difference_biomass_step_unit.sv]
// Each accepted word is run through the 18 sequencer steps; the next word is accepted only
// once the sequencer is idle again. The single shared 32x32 multiplier is used at 15 of
// the 18 steps. The final step stalls until the output register is free.
// The output register lets the next word be accepted while a result waits.
// Reset (rst_n, synchronous, active low) clears config, model state and valids.
// Depends on dds_pkg, dds_if, dds_ctrl, dds_datapath.
module delay_difference_biomass_step_unit import dds_pkg::*; #(
  parameter int unsigned MONTHS_PER_YEAR = MonthsPerYearDef,
  parameter int unsigned RECRUIT_MONTH   = RecruitMonthDef
) (
  input  logic                  clk,
  input  logic                  rst_n,
  dds_in_if.sink                in_ch,
  dds_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dds_cmd_t cmd;

  dds_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  dds_datapath #(
    .MONTHS_PER_YEAR (MONTHS_PER_YEAR),
    .RECRUIT_MONTH   (RECRUIT_MONTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_et       (in_ch.effort_targeted),
    .in_en       (in_ch.effort_nontargeted),
    .in_yr       (in_ch.year_recruitment),
    .in_start    (in_ch.series_start),
    .out_biomass (out_ch.biomass),
    .out_clamped (out_ch.clamped)
  );

endmodule
